// File: hw/rtl/adpcm_pcm_wave_decoder_macros.svh
`ifndef ADPCM_PCM_WAVE_DECODER_MACROS_SVH
`define ADPCM_PCM_WAVE_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define APWD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define APWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/apwd_pkg.sv
`timescale 1ns / 1ps

package apwd_pkg;

  localparam int BYTE_W     = 8;
  localparam int SAMPLE_W   = 16;
  localparam int LIMIT_W    = 27;
  localparam int FORMAT_W   = 2;
  localparam int COEF_W     = 14;
  localparam int FRAME_MAX  = 9;
  localparam int POS_W      = 4;
  localparam int K_W        = 4;
  localparam int PROD_W     = COEF_W + SAMPLE_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int PRED_SHIFT = 11;
  localparam int SCALED_W   = 20;
  localparam int SUM_W      = SCALED_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LIMIT_W;

  // frame lengths in bytes
  localparam logic [POS_W-1:0] LEN_ADPCM4 = POS_W'(9);
  localparam logic [POS_W-1:0] LEN_ADPCM2 = POS_W'(5);

  typedef enum logic [FORMAT_W-1:0] {
    FMT_ADPCM4 = 2'd0,
    FMT_ADPCM2 = 2'd1,
    FMT_PCM8   = 2'd2,
    FMT_PCM16  = 2'd3
  } fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVE_FORMAT  = 1'b0,
    REG_SAMPLE_LIMIT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_MUL_NEW = 2'd1,
    ST_MUL_OLD = 2'd2,
    ST_FIN     = 2'd3
  } seq_state_t;

  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // multiply-accumulate control
  typedef struct packed {
    logic en;
    logic clear;
  } mac_ctrl_t;

  // frame buffer write
  typedef struct packed {
    logic              en;
    logic [POS_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } buf_wr_t;

  // weight on the newer history sample
  function automatic coef_t coef_new(input logic [3:0] p);
    coef_t c;
    case (p)
      4'd0:    c = 14'sh0000;
      4'd1:    c = 14'sh0800;
      4'd2:    c = 14'sh0000;
      4'd3:    c = 14'sh0400;
      4'd4:    c = 14'sh1000;
      4'd5:    c = 14'sh0e00;
      4'd6:    c = 14'sh0c00;
      4'd7:    c = 14'sh1200;
      4'd8:    c = 14'sh1068;
      4'd9:    c = 14'sh12c0;
      4'd10:   c = 14'sh1400;
      4'd11:   c = 14'sh0800;
      4'd12:   c = 14'sh0400;
      4'd13:   c = -14'sh0400;
      4'd14:   c = -14'sh0400;
      default: c = -14'sh0800;
    endcase
    return c;
  endfunction

  // weight on the older history sample
  function automatic coef_t coef_old(input logic [3:0] p);
    coef_t c;
    case (p)
      4'd0:    c = 14'sh0000;
      4'd1:    c = 14'sh0000;
      4'd2:    c = 14'sh0800;
      4'd3:    c = 14'sh0400;
      4'd4:    c = -14'sh0800;
      4'd5:    c = -14'sh0600;
      4'd6:    c = -14'sh0400;
      4'd7:    c = -14'sh0a00;
      4'd8:    c = -14'sh08c8;
      4'd9:    c = -14'sh08fc;
      4'd10:   c = -14'sh0c00;
      4'd11:   c = -14'sh0800;
      4'd12:   c = -14'sh0400;
      4'd13:   c = 14'sh0400;
      4'd14:   c = 14'sh0000;
      default: c = 14'sh0000;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/apwd_in_if.sv
`timescale 1ns / 1ps

interface apwd_in_if import apwd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              wave_start;

  modport source (output valid, output data_byte, output wave_start, input ready);
  modport sink   (input valid, input data_byte, input wave_start, output ready);
endinterface

// File: hw/rtl/apwd_out_if.sv
`timescale 1ns / 1ps

interface apwd_out_if import apwd_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] pcm_sample;
  logic                       run_last;

  modport source (output valid, output pcm_sample, output run_last, input ready);
  modport sink   (input valid, input pcm_sample, input run_last, output ready);
endinterface

// File: hw/rtl/apwd_mac.sv
`timescale 1ns / 1ps

module apwd_mac import apwd_pkg::*; (
  input  logic      clk,
  input  mac_ctrl_t ctrl,
  input  coef_t     coef,
  input  sample_t   smp,
  output acc_t      acc
);

  logic signed [PROD_W-1:0] prod;
  acc_t acc_r;
  acc_t acc_nxt;

  // one shared signed multiplier
  assign prod = coef * smp;

  // when enabled, clear loads the product, otherwise accumulate
  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.en) begin
      if (ctrl.clear) begin
        acc_nxt = ACC_W'(prod);
      end else begin
        acc_nxt = acc_r + ACC_W'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// File: hw/rtl/apwd_frame_buf.sv
`timescale 1ns / 1ps

module apwd_frame_buf import apwd_pkg::*; (
  input  logic              clk,
  input  buf_wr_t           wr,
  input  logic [POS_W-1:0]  rd_addr,
  output logic [BYTE_W-1:0] header,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] bytes_r [FRAME_MAX];

  // one byte written per transfer
  always_ff @(posedge clk) begin
    if (wr.en) begin
      bytes_r[wr.addr] <= wr.data;
    end
  end

  // header sits at a fixed place, residual bytes at one selected place
  assign header  = bytes_r[0];
  assign rd_data = bytes_r[rd_addr];

endmodule

// File: hw/rtl/adpcm_pcm_wave_decoder.sv
`timescale 1ns / 1ps
`include "adpcm_pcm_wave_decoder_macros.svh"

// channel   dir  payload                          transfer when
// in_ch     in   data_byte[7:0], wave_start       valid && ready
// out_ch    out  pcm_sample[15:0] s, run_last     valid && ready
// cfg_*     in   cfg_index[0], cfg_data[26:0]     cfg_we
//
// a byte that completes no frame or is pcm leaves the sequencer idle
// a completed adpcm frame is decoded one sample at a time on the shared multiplier
// (two products per sample, then clamp), up to 16 samples per frame
// in_ready is low while a frame decodes; a stalled output holds the sequencer
// rst_n is synchronous, active low; it clears config, control, history and counters

module adpcm_pcm_wave_decoder import apwd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  apwd_in_if.sink                in_ch,
  apwd_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration
  fmt_t               fmt_r;
  logic [LIMIT_W-1:0] limit_r;

  // sequencer and wave state
  seq_state_t         state_r, state_nxt;
  logic [K_W-1:0]     k_r, k_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [LIMIT_W-1:0] cnt_r, cnt_nxt;
  logic               pend_r, pend_nxt;
  logic [BYTE_W-1:0]  hi_r, hi_nxt;
  sample_t            older_r, older_nxt;
  sample_t            newer_r, newer_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  sample_t            out_sample_r, out_sample_nxt;
  logic               out_last_r, out_last_nxt;

  // datapath
  logic               in_go;
  logic               out_free;
  logic [LIMIT_W-1:0] cnt_eff;
  logic [POS_W-1:0]   pos_eff;
  logic [POS_W-1:0]   pos_inc;
  logic [POS_W-1:0]   frame_len;
  logic               pend_eff;
  logic               room;
  logic               fin_go;
  logic               fin_last;
  mac_ctrl_t          mac_ctrl;
  coef_t              mac_coef;
  sample_t            mac_smp;
  acc_t               acc;
  buf_wr_t            buf_wr;
  logic [POS_W-1:0]   rd_addr;
  logic [BYTE_W-1:0]  header;
  logic [BYTE_W-1:0]  res_byte;
  logic [1:0]         pair;
  logic signed [3:0]  resid;
  logic signed [SCALED_W-1:0] scaled;
  logic signed [SCALED_W-1:0] pred;
  logic signed [SUM_W-1:0]    sum;
  sample_t            dec_sample;

  apwd_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .coef (mac_coef),
    .smp  (mac_smp),
    .acc  (acc)
  );

  apwd_frame_buf u_buf (
    .clk     (clk),
    .wr      (buf_wr),
    .rd_addr (rd_addr),
    .header  (header),
    .rd_data (res_byte)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_ADPCM4;
      limit_r <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WAVE_FORMAT:  fmt_r   <= fmt_t'(cfg_data[FORMAT_W-1:0]);
        REG_SAMPLE_LIMIT: limit_r <= cfg_data[LIMIT_W-1:0];
        default:          limit_r <= limit_r;
      endcase
    end
  end

  // handshakes
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && out_free;
  assign in_go        = in_ch.valid && in_ch.ready;

  // wave start clears before the byte is used
  assign cnt_eff   = in_ch.wave_start ? '0 : cnt_r;
  assign pos_eff   = in_ch.wave_start ? '0 : pos_r;
  assign pend_eff  = in_ch.wave_start ? 1'b0 : pend_r;
  assign pos_inc   = pos_eff + POS_W'(1);
  assign frame_len = (fmt_r == FMT_ADPCM4) ? LEN_ADPCM4 : LEN_ADPCM2;
  assign room      = cnt_eff < limit_r;

  assign buf_wr.en   = in_go && ((fmt_r == FMT_ADPCM4) || (fmt_r == FMT_ADPCM2));
  assign buf_wr.addr = pos_eff;
  assign buf_wr.data = in_ch.data_byte;

  // residual pick
  always_comb begin
    if (fmt_r == FMT_ADPCM4) begin
      rd_addr = POS_W'(1) + POS_W'(k_r[3:1]);
    end else begin
      rd_addr = POS_W'(1) + POS_W'(k_r[3:2]);
    end
    case (k_r[1:0])
      2'd0:    pair = res_byte[7:6];
      2'd1:    pair = res_byte[5:4];
      2'd2:    pair = res_byte[3:2];
      default: pair = res_byte[1:0];
    endcase
    if (fmt_r == FMT_ADPCM4) begin
      resid = k_r[0] ? res_byte[3:0] : res_byte[7:4];
    end else begin
      resid = {{2{pair[1]}}, pair};
    end
  end

  // sample = clamp(residual * 2^exp + floor(acc / 2048))
  assign scaled = SCALED_W'(resid) <<< header[7:4];
  assign pred   = SCALED_W'(acc >>> PRED_SHIFT);
  assign sum    = SUM_W'(scaled) + SUM_W'(pred);

  always_comb begin
    if (sum > 21'sd32767) begin
      dec_sample = 16'sh7fff;
    end else if (sum < -21'sd32768) begin
      dec_sample = 16'sh8000;
    end else begin
      dec_sample = sum[SAMPLE_W-1:0];
    end
  end

  // multiplier operands
  always_comb begin
    mac_ctrl.en    = (state_r == ST_MUL_NEW) || (state_r == ST_MUL_OLD);
    mac_ctrl.clear = (state_r == ST_MUL_NEW);
    if (state_r == ST_MUL_NEW) begin
      mac_coef = coef_new(header[3:0]);
      mac_smp  = newer_r;
    end else begin
      mac_coef = coef_old(header[3:0]);
      mac_smp  = older_r;
    end
  end

  assign fin_go   = (state_r == ST_FIN) && out_free;
  assign fin_last = (k_r == K_W'(15)) || ((cnt_r + LIMIT_W'(1)) == limit_r);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    hi_nxt         = hi_r;
    older_nxt      = older_r;
    newer_nxt      = newer_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_go) begin
          cnt_nxt  = cnt_eff;
          pos_nxt  = pos_eff;
          pend_nxt = pend_eff;
          if (in_ch.wave_start) begin
            older_nxt = '0;
            newer_nxt = '0;
          end
          case (fmt_r)
            FMT_ADPCM4, FMT_ADPCM2: begin
              if (pos_inc >= frame_len) begin
                pos_nxt = '0;
                k_nxt   = '0;
                if (room) begin
                  state_nxt = ST_MUL_NEW;
                end
              end else begin
                pos_nxt = pos_inc;
              end
            end
            FMT_PCM8: begin
              if (room) begin
                out_valid_nxt  = 1'b1;
                out_sample_nxt = {in_ch.data_byte, 8'h00};
                out_last_nxt   = 1'b1;
                cnt_nxt        = cnt_eff + LIMIT_W'(1);
              end
            end
            default: begin
              if (!pend_eff) begin
                hi_nxt   = in_ch.data_byte;
                pend_nxt = 1'b1;
              end else begin
                pend_nxt = 1'b0;
                if (room) begin
                  out_valid_nxt  = 1'b1;
                  out_sample_nxt = {hi_r, in_ch.data_byte};
                  out_last_nxt   = 1'b1;
                  cnt_nxt        = cnt_eff + LIMIT_W'(1);
                end
              end
            end
          endcase
        end
      end
      ST_MUL_NEW: begin
        state_nxt = ST_MUL_OLD;
      end
      ST_MUL_OLD: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = dec_sample;
          out_last_nxt   = fin_last;
          older_nxt      = newer_r;
          newer_nxt      = dec_sample;
          cnt_nxt        = cnt_r + LIMIT_W'(1);
          k_nxt          = k_r + K_W'(1);
          state_nxt      = fin_last ? ST_IDLE : ST_MUL_NEW;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      older_r     <= '0;
      newer_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      older_r     <= older_nxt;
      newer_r     <= newer_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hi_r         <= hi_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pcm_sample = out_sample_r;
  assign out_ch.run_last   = out_last_r;

  // checks
  `APWD_ASSERT_NOW(a_pos_range, 1'b1, pos_r < LEN_ADPCM4, "frame position past frame end")
  `APWD_ASSERT_NOW(a_fin_room, fin_go, cnt_r < limit_r, "adpcm sample past sample limit")
  `APWD_ASSERT_NEXT(a_last_idle, fin_go && fin_last, state_r == ST_IDLE, "decode runs past last")

endmodule

// File: tb/apwd_wave_checker.sv
`timescale 1ns / 1ps

module apwd_wave_checker import apwd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  apwd_in_if                    in_ch,
  apwd_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding,
  output int                    checked
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pcm;
    logic                       last;
  } sample_exp_t;

  // predictor weights, indexed by the low nibble of the frame header
  localparam int WEIGHT_NEW [16] = '{0, 'h800, 0, 'h400, 'h1000, 'he00, 'hc00, 'h1200,
                                     'h1068, 'h12c0, 'h1400, 'h800, 'h400, -'h400, -'h400,
                                     -'h800};
  localparam int WEIGHT_OLD [16] = '{0, 0, 'h800, 'h400, -'h800, -'h600, -'h400, -'ha00,
                                     -'h8c8, -'h8fc, -'hc00, -'h800, -'h400, 'h400, 0, 0};

  sample_exp_t pending_samples [$];
  sample_exp_t want;

  // shadow configuration and decoder state
  fmt_t        fmt;
  int          limit;
  int          older;
  int          newer;
  logic [7:0]  frame_mem [FRAME_MAX];
  int          pos;
  int          emitted;
  bit          hb_pend;
  logic [7:0]  hb;
  int          per_byte;
  int          err_cnt;
  int          n_checked;

  task automatic note_mismatch(input string what);
    if (err_cnt < 10) $display("%s", what);
    err_cnt++;
  endtask

  task automatic record_sample(input int s);
    sample_exp_t e;
    e.pcm  = s[SAMPLE_W-1:0];
    e.last = 1'b0;
    pending_samples = {pending_samples, e};
    emitted++;
    per_byte++;
  endtask

  // runs the buffered frame through the two-tap predictor, stopping at the limit
  task automatic decode_frame(input bit two_bit);
    logic [7:0] hdr;
    logic [7:0] b;
    logic [3:0] nib;
    logic [1:0] pair;
    int         r;
    int         pred;
    int         s;
    int         k;
    hdr = frame_mem[0];
    for (k = 0; k < 16; k++) begin
      if (emitted >= limit) break;
      if (!two_bit) begin
        b   = frame_mem[1 + k / 2];
        nib = k[0] ? b[3:0] : b[7:4];
        r   = (nib >= 8) ? int'(nib) - 16 : int'(nib);
      end else begin
        b    = frame_mem[1 + k / 4];
        pair = b >> (6 - 2 * (k % 4));
        r    = (pair >= 2) ? int'(pair) - 4 : int'(pair);
      end
      // arithmetic shift gives the floor of the weighted sum
      pred = (WEIGHT_NEW[hdr[3:0]] * newer + WEIGHT_OLD[hdr[3:0]] * older) >>> PRED_SHIFT;
      s = r * (1 << hdr[7:4]) + pred;
      if (s > 32767) s = 32767;
      else if (s < -32768) s = -32768;
      older = newer;
      newer = s;
      record_sample(s);
    end
  endtask

  // expected samples for one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic st);
    per_byte = 0;
    if (st) begin
      older   = 0;
      newer   = 0;
      pos     = 0;
      emitted = 0;
      hb_pend = 1'b0;
    end
    case (fmt)
      FMT_ADPCM4, FMT_ADPCM2: begin
        frame_mem[pos % FRAME_MAX] = b;
        pos++;
        // frame length follows the format in force now, position carries over
        if (pos >= ((fmt == FMT_ADPCM4) ? int'(LEN_ADPCM4) : int'(LEN_ADPCM2))) begin
          pos = 0;
          decode_frame(fmt == FMT_ADPCM2);
        end
      end
      FMT_PCM8: begin
        if (emitted < limit) record_sample(int'(signed'({b, 8'h00})));
      end
      default: begin
        if (!hb_pend) begin
          hb      = b;
          hb_pend = 1'b1;
        end else begin
          hb_pend = 1'b0;
          if (emitted < limit) record_sample(int'(signed'({hb, b})));
        end
      end
    endcase
    // flag the final sample of this byte
    if (per_byte > 0) begin
      pending_samples[pending_samples.size() - 1].last = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_samples.delete();
      fmt       = FMT_ADPCM4;
      limit     = 0;
      older     = 0;
      newer     = 0;
      pos       = 0;
      emitted   = 0;
      hb_pend   = 1'b0;
      err_cnt   = 0;
      n_checked = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == REG_WAVE_FORMAT) fmt = fmt_t'(cfg_data[FORMAT_W-1:0]);
        else limit = int'(cfg_data);
      end
      // input transfer
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.data_byte, in_ch.wave_start);
      // output transfer against the oldest expected sample
      if (out_ch.valid && out_ch.ready) begin
        if (pending_samples.size() == 0) begin
          note_mismatch($sformatf("extra sample %0d last %0b with nothing expected",
                                  out_ch.pcm_sample, out_ch.run_last));
        end else begin
          want = pending_samples.pop_front();
          n_checked++;
          if (out_ch.pcm_sample !== want.pcm || out_ch.run_last !== want.last)
            note_mismatch($sformatf("sample %0d: expected %0d last %0b, got %0d last %0b",
                                    n_checked, want.pcm, want.last,
                                    out_ch.pcm_sample, out_ch.run_last));
        end
      end
    end
    mismatches  <= err_cnt;
    outstanding <= pending_samples.size();
    checked     <= n_checked;
  end

endmodule

// File: tb/tb_adpcm_pcm_wave_decoder.sv
`timescale 1ns / 1ps

module tb_adpcm_pcm_wave_decoder;
  import apwd_pkg::*;

  localparam int CYCLE_LIMIT    = 250000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int BYTE_TARGET    = 410;
  localparam int QUIET_FROM     = 340;
  localparam int LIMIT_TOP      = 100000000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int err_total;
  int left_total;
  int seen_total;
  int cycle_cnt    = 0;
  int sent         = 0;
  int phases       = 0;
  bit idling       = 1'b1;
  bit squeeze      = 1'b0;
  bit squeeze_done = 1'b0;

  apwd_in_if  in_if();
  apwd_out_if out_if();

  adpcm_pcm_wave_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if.sink),
    .out_ch    (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  apwd_wave_checker i_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (err_total),
    .outstanding (left_total),
    .checked     (seen_total)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // sample sink: random stall bursts, plus one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze && !squeeze_done) begin
        out_if.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // one byte transfer, with an optional gap in front of it
  task automatic push_byte(input logic [7:0] b, input logic st);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.wave_start <= st;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent++;
  endtask

  // stop offering, drain every expected sample, then let the block go quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (left_total != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes both registers on consecutive edges
  task automatic set_config(input fmt_t f, input int lim);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WAVE_FORMAT;
    cfg_data  <= CFG_DATA_W'(f);
    @(posedge clk);
    cfg_index <= REG_SAMPLE_LIMIT;
    cfg_data  <= CFG_DATA_W'(lim);
    @(posedge clk);
    cfg_we    <= 1'b0;
    phases++;
  endtask

  // whole frames or pcm words with random content, sometimes a stray start
  // or a trailing partial frame
  task automatic send_wave(input fmt_t f, input bit fresh);
    int         unit_len;
    int         units;
    int         tail;
    int         u;
    int         j;
    logic [7:0] b;
    bit         st;
    case (f)
      FMT_ADPCM4: begin
        unit_len = int'(LEN_ADPCM4);
        units    = $urandom_range(1, 3);
      end
      FMT_ADPCM2: begin
        unit_len = int'(LEN_ADPCM2);
        units    = $urandom_range(1, 4);
      end
      FMT_PCM8: begin
        unit_len = 1;
        units    = $urandom_range(1, 16);
      end
      default: begin
        unit_len = 2;
        units    = $urandom_range(1, 8);
      end
    endcase
    for (u = 0; u < units; u++) begin
      for (j = 0; j < unit_len; j++) begin
        b = 8'($urandom_range(0, 255));
        // small exponents half the time keep samples off the rails
        if (j == 0 && (f == FMT_ADPCM4 || f == FMT_ADPCM2))
          b[7:4] = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 5));
        st = (fresh && u == 0 && j == 0) || $urandom_range(0, 59) == 0;
        push_byte(b, st);
      end
    end
    if (unit_len > 1 && $urandom_range(0, 3) == 0) begin
      tail = $urandom_range(1, unit_len - 1);
      repeat (tail) push_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    fmt_t f;
    int   lim;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_WAVE_FORMAT;
    cfg_data         <= '0;
    in_if.valid      <= 1'b0;
    in_if.data_byte  <= '0;
    in_if.wave_start <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // 4-bit frame at the largest exponent: both clamps and all residual extremes
    set_config(FMT_ADPCM4, LIMIT_TOP);
    push_byte(8'hF7, 1'b1);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h08, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h77, 1'b0);
    push_byte(8'h88, 1'b0);
    settle();

    // 2-bit frame cut short by the limit
    set_config(FMT_ADPCM2, 5);
    push_byte(8'h0F, 1'b1);
    push_byte(8'h1B, 1'b0);
    push_byte(8'hE4, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    settle();

    // limit raised mid-wave, format switched to pcm8 without a start
    set_config(FMT_PCM8, 7);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFF, 1'b0);
    settle();

    // zero limit swallows a pcm16 word
    set_config(FMT_PCM16, 0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b0);
    settle();

    // pending high byte dropped by a start, the most negative word, odd byte left over
    set_config(FMT_PCM16, LIMIT_TOP);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h12, 1'b1);
    push_byte(8'h34, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    settle();

    // partial 4-bit frame completed under the 2-bit frame length
    set_config(FMT_ADPCM4, LIMIT_TOP);
    push_byte(8'h2A, 1'b1);
    push_byte(8'h91, 1'b0);
    push_byte(8'h5E, 1'b0);
    settle();
    set_config(FMT_ADPCM2, LIMIT_TOP);
    push_byte(8'h6D, 1'b0);
    push_byte(8'hC3, 1'b0);
    settle();

    // back-pressure: sink holds off while frames keep coming
    set_config(FMT_ADPCM4, LIMIT_TOP);
    squeeze = 1'b1;
    send_wave(FMT_ADPCM4, 1'b1);
    send_wave(FMT_ADPCM4, 1'b0);
    send_wave(FMT_ADPCM4, 1'b0);
    settle();

    // random phases: a fresh setting each time, waves mostly well formed
    while (sent < BYTE_TARGET) begin
      if (sent >= QUIET_FROM) idling = 1'b0;
      f = fmt_t'(FORMAT_W'($urandom_range(0, 3)));
      case ($urandom_range(0, 9))
        0:       lim = 0;
        1:       lim = LIMIT_TOP;
        2, 3:    lim = $urandom_range(1, 40);
        default: lim = $urandom_range(41, 5000);
      endcase
      set_config(f, lim);
      repeat ($urandom_range(1, 3)) send_wave(f, $urandom_range(0, 4) != 0);
      settle();
    end

    $display("run covered %0d bytes over %0d register settings", sent, phases);
    $display("%0d samples compared, %0d mismatches", seen_total, err_total);
    if (err_total == 0 && left_total == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
